>>> design/tccs_pkg.sv
// ----------------------------------------------------------------------------
// tccs_pkg
// shared types and constants of the text console engine
// ----------------------------------------------------------------------------
package tccs_pkg;

    // screen geometry
    localparam int COLS  = 80;
    localparam int ROWS  = 25;
    localparam int CELLS = COLS * ROWS;

    // cell address width and sweep counter width (counter can hold CELLS)
    localparam int AW = $clog2(CELLS);
    localparam int CW = $clog2(CELLS + 1);

    // payload field widths
    localparam int KIND_W = 3;
    localparam int CHAR_W = 8;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int LIN_W  = 11;

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

    // command codes
    localparam logic [KIND_W-1:0] KIND_PUT   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DEL   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd2;
    localparam logic [KIND_W-1:0] KIND_HOME  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ  = 3'd4;

    // line break codes
    localparam logic [CHAR_W-1:0] CODE_NL = 8'd10;
    localparam logic [CHAR_W-1:0] CODE_CR = 8'd13;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_SCROLL,
        S_CLEAR,
        S_RESP
    } t_state;

endpackage

>>> design/text_console_cursor_scroll_top.sv
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_top
// character console engine with cursor, backspace, clear and scroll
// ----------------------------------------------------------------------------
// A request is accepted only in the idle state. After reset the block first
// zeroes the whole character store, one cell per cycle over all CELLS = 2000
// cells, with o_in_ready low. Put char, delete, home, unused kinds and reads of
// a cell outside the screen pass from acceptance through the execute state,
// which touches the store and loads the result register, or waits in the
// response state while that register is full. Read cell of a cell on the
// screen adds a wait state for the registered read port of the store. A scroll
// walks the store once, copying each row up by one and blanking the bottom row;
// a clear writes zero to every cell. Both walks are bound by the single write
// port of the store.
// The result register decouples the output side: a new request may be
// accepted while the previous result still waits to be taken.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [tccs_pkg::KIND_W-1:0] i_kind,
    input  logic [tccs_pkg::CHAR_W-1:0] i_char_code,
    input  logic [tccs_pkg::ROW_W-1:0]  i_read_row,
    input  logic [tccs_pkg::COL_W-1:0]  i_read_col,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [tccs_pkg::CHAR_W-1:0] o_cell_char,
    output logic [tccs_pkg::COL_W-1:0]  o_cur_col,
    output logic [tccs_pkg::ROW_W-1:0]  o_cur_row,
    output logic [tccs_pkg::LIN_W-1:0]  o_cur_linear
);
    import tccs_pkg::*;

    // row-major cell address
    function automatic logic [AW-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                input logic [COL_W-1:0] col);
        return AW'(row * COLS + col);
    endfunction

    function automatic logic [LIN_W-1:0] lin_pos(input logic [ROW_W-1:0] row,
                                                 input logic [COL_W-1:0] col);
        return LIN_W'(row * COLS + col);
    endfunction

    // control state
    t_state             r_state, n_state;
    logic [CW-1:0]      r_idx,   n_idx;
    logic [COL_W-1:0]   r_col,   n_col;
    logic [ROW_W-1:0]   r_row,   n_row;
    logic [CHAR_W-1:0]  r_cell,  n_cell;

    // latched request
    logic [KIND_W-1:0]  r_kind;
    logic [CHAR_W-1:0]  r_code;
    logic [ROW_W-1:0]   r_rrow;
    logic [COL_W-1:0]   r_rcol;

    // character store, one write and one read port
    logic [CHAR_W-1:0]  r_mem [CELLS];
    logic [CHAR_W-1:0]  r_rdata;
    logic               mem_we, mem_re;
    logic [AW-1:0]      mem_waddr, mem_raddr;
    logic [CHAR_W-1:0]  mem_wdata;

    // result register
    logic               r_o_valid;
    logic [CHAR_W-1:0]  r_o_char;
    logic [COL_W-1:0]   r_o_col;
    logic [ROW_W-1:0]   r_o_row;
    logic [LIN_W-1:0]   r_o_lin;

    // result load request from the sequencer
    logic               emit;
    logic [CHAR_W-1:0]  e_char;
    logic [COL_W-1:0]   e_col;
    logic [ROW_W-1:0]   e_row;
    logic               out_free;
    logic               accept;

    assign out_free   = !r_o_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // sequencer: next state, cursor update and store access
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_col     = r_col;
        n_row     = r_row;
        n_cell    = r_cell;
        mem_we    = 1'b0;
        mem_waddr = cell_addr(r_row, r_col);
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = cell_addr(r_rrow, r_rcol);
        emit      = 1'b0;
        e_char    = '0;
        e_col     = r_col;
        e_row     = r_row;

        case (r_state)
            // zero the store after reset, nothing accepted meanwhile
            S_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx[AW-1:0];
                n_idx     = r_idx + 1'b1;
                if (r_idx == CW'(CELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                n_cell = '0;
                n_idx  = '0;
                // plain commands finish here
                n_state = out_free ? S_IDLE : S_RESP;
                case (r_kind)
                    KIND_PUT: begin
                        if (r_code == CODE_NL || r_code == CODE_CR) begin
                            n_col = '0;
                            if (r_row == LAST_ROW) begin
                                n_state = S_SCROLL;
                            end else begin
                                n_row = r_row + 1'b1;
                            end
                        end else begin
                            // store at cursor, then advance with wrap
                            mem_we    = 1'b1;
                            mem_waddr = cell_addr(r_row, r_col);
                            mem_wdata = r_code;
                            if (r_col == LAST_COL) begin
                                n_col = '0;
                                if (r_row == LAST_ROW) begin
                                    n_state = S_SCROLL;
                                end else begin
                                    n_row = r_row + 1'b1;
                                end
                            end else begin
                                n_col = r_col + 1'b1;
                            end
                        end
                    end
                    KIND_DEL: begin
                        if (r_col == '0 && r_row != '0) begin
                            // back across the line start
                            n_row     = r_row - 1'b1;
                            n_col     = LAST_COL;
                            mem_we    = 1'b1;
                            mem_waddr = cell_addr(r_row - 1'b1, LAST_COL);
                        end else if (r_col != '0) begin
                            n_col     = r_col - 1'b1;
                            mem_we    = 1'b1;
                            mem_waddr = cell_addr(r_row, r_col - 1'b1);
                        end
                    end
                    KIND_CLEAR: begin
                        n_state = S_CLEAR;
                    end
                    KIND_HOME: begin
                        n_col = '0;
                        n_row = '0;
                    end
                    KIND_READ: begin
                        if (r_rrow < ROWS && r_rcol < COLS) begin
                            mem_re    = 1'b1;
                            mem_raddr = cell_addr(r_rrow, r_rcol);
                            n_state   = S_RDWAIT;
                        end
                    end
                    default: begin
                    end
                endcase
                if (n_state == S_IDLE) begin
                    emit  = 1'b1;
                    e_col = n_col;
                    e_row = n_row;
                end
            end

            // read data arrives in the cycle after the address
            S_RDWAIT: begin
                n_cell = r_rdata;
                if (out_free) begin
                    emit    = 1'b1;
                    e_char  = r_rdata;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_RESP;
                end
            end

            // copy cell idx+COLS to idx, the write comes in the cycle after its read
            S_SCROLL: begin
                if (r_idx < CW'(CELLS - COLS)) begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(r_idx + CW'(COLS));
                end
                if (r_idx != '0) begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(r_idx - 1'b1);
                    // bottom row is blanked
                    mem_wdata = (r_idx <= CW'(CELLS - COLS)) ? r_rdata : '0;
                end
                n_idx = r_idx + 1'b1;
                if (r_idx == CW'(CELLS)) begin
                    n_state = S_RESP;
                end
            end

            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx[AW-1:0];
                n_idx     = r_idx + 1'b1;
                if (r_idx == CW'(CELLS - 1)) begin
                    n_state = S_RESP;
                end
            end

            // result waits for a free output register
            S_RESP: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_char  = r_cell;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_idx   <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_cell  <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_col   <= n_col;
            r_row   <= n_row;
            r_cell  <= n_cell;
        end
    end

    // request payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_kind;
            r_code <= i_char_code;
            r_rrow <= i_read_row;
            r_rcol <= i_read_col;
        end
    end

    // character store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (emit) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_o_char <= e_char;
            r_o_col  <= e_col;
            r_o_row  <= e_row;
            r_o_lin  <= lin_pos(e_row, e_col);
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_cell_char  = r_o_char;
    assign o_cur_col    = r_o_col;
    assign o_cur_row    = r_o_row;
    assign o_cur_linear = r_o_lin;

endmodule

>>> dv/console_tracker_pkg.sv
// ----------------------------------------------------------------------------
// console_tracker_pkg
// screen and cursor tracker for the text console engine testbench
// ----------------------------------------------------------------------------
package console_tracker_pkg;

    import tccs_pkg::*;

    // kinds that the engine ignores apart from reporting the cursor
    localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [CHAR_W-1:0] cell_char;
        logic [COL_W-1:0]  cur_col;
        logic [ROW_W-1:0]  cur_row;
        logic [LIN_W-1:0]  cur_linear;
    } t_console_result;

    class console_tracker;

        logic [CHAR_W-1:0] screen [CELLS];
        int unsigned       col;
        int unsigned       row;
        t_console_result   awaited_q [$];
        int unsigned       result_num;

        function new();
            foreach (screen[i]) screen[i] = '0;
            col        = 0;
            row        = 0;
            result_num = 0;
        endfunction

        // every row moves up by one, bottom row goes blank
        function void scroll_screen();
            for (int i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
            for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = '0;
        endfunction

        function void print_byte(logic [CHAR_W-1:0] code);
            if (code == CODE_NL || code == CODE_CR) begin
                col = 0;
                row++;
                if (row >= ROWS) begin
                    scroll_screen();
                    row = ROWS - 1;
                end
                return;
            end
            screen[row * COLS + col] = code;
            col++;
            if (col >= COLS) begin
                col = 0;
                if (row + 1 >= ROWS) begin
                    scroll_screen();
                    row = ROWS - 1;
                end else begin
                    row++;
                end
            end
        endfunction

        function void erase_back();
            if (col == 0 && row > 0) begin
                row--;
                col = COLS;
            end
            if (col > 0) begin
                col--;
                screen[row * COLS + col] = '0;
            end
        endfunction

        // accepted request: advance the tracked state, queue the awaited result
        function void note_command(logic [KIND_W-1:0] kind, logic [CHAR_W-1:0] code,
                                   logic [ROW_W-1:0] rd_row, logic [COL_W-1:0] rd_col);
            t_console_result res;
            logic [CHAR_W-1:0] rd_char;
            rd_char = '0;
            case (kind)
                KIND_PUT:   print_byte(code);
                KIND_DEL:   erase_back();
                KIND_CLEAR: foreach (screen[i]) screen[i] = '0;
                KIND_HOME: begin
                    col = 0;
                    row = 0;
                end
                KIND_READ: begin
                    if (rd_row < ROWS && rd_col < COLS)
                        rd_char = screen[rd_row * COLS + rd_col];
                end
                default: ;
            endcase
            res.cell_char  = rd_char;
            res.cur_col    = COL_W'(col);
            res.cur_row    = ROW_W'(row);
            res.cur_linear = LIN_W'(row * COLS + col);
            awaited_q.push_back(res);
        endfunction

        // empty string when the result matches the oldest awaited one
        function string check_result(t_console_result got);
            t_console_result want;
            string msg;
            msg = "";
            result_num++;
            if (awaited_q.size() == 0)
                return $sformatf("result %0d arrived with no request outstanding", result_num);
            want = awaited_q.pop_front();
            if (got.cell_char !== want.cell_char)
                msg = {msg, $sformatf(" cell_char exp %0d got %0d", want.cell_char, got.cell_char)};
            if (got.cur_col !== want.cur_col)
                msg = {msg, $sformatf(" cur_col exp %0d got %0d", want.cur_col, got.cur_col)};
            if (got.cur_row !== want.cur_row)
                msg = {msg, $sformatf(" cur_row exp %0d got %0d", want.cur_row, got.cur_row)};
            if (got.cur_linear !== want.cur_linear)
                msg = {msg, $sformatf(" cur_linear exp %0d got %0d",
                                      want.cur_linear, got.cur_linear)};
            if (msg != "") msg = {$sformatf("result %0d:", result_num), msg};
            return msg;
        endfunction

        function int outstanding();
            return awaited_q.size();
        endfunction

    endclass

endpackage

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives console commands into the text console engine and checks every
// result against a tracked copy of the screen and cursor
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import tccs_pkg::*;
    import console_tracker_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 10;
    localparam int ITEM_TARGET   = 400;
    localparam int IDLE_PCT      = 8;       // chance of an idle cycle on either side
    localparam int HOLD_CYCLES   = 400;     // long result-side hold-off
    localparam int DRAIN_CYCLES  = 20;      // settle time after the last result
    localparam int WATCHDOG      = 20000;   // cycles with no handshake at all
    localparam int MAX_REPORTS   = 50;

    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    logic [KIND_W-1:0]  i_kind      = '0;
    logic [CHAR_W-1:0]  i_char_code = '0;
    logic [ROW_W-1:0]   i_read_row  = '0;
    logic [COL_W-1:0]   i_read_col  = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [CHAR_W-1:0]  o_cell_char;
    logic [COL_W-1:0]   o_cur_col;
    logic [ROW_W-1:0]   o_cur_row;
    logic [LIN_W-1:0]   o_cur_linear;

    console_tracker tracker = new();

    int  errors       = 0;
    int  sent         = 0;     // requests accepted so far
    int  quiet_cycles = 0;
    int  hold_left    = 0;
    bit  hold_pending = 1'b0;  // main flow asks the result side for a long hold-off
    bit  calm         = 1'b0;  // no random idling on either side while set

    text_console_cursor_scroll_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_char_code  (i_char_code),
        .i_read_row   (i_read_row),
        .i_read_col   (i_read_col),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_cell_char  (o_cell_char),
        .o_cur_col    (o_cur_col),
        .o_cur_row    (o_cur_row),
        .o_cur_linear (o_cur_linear)
    );

    always begin
        i_clk = 1'b0;
        #CLK_HALF;
        i_clk = 1'b1;
        #CLK_HALF;
    end

    task automatic report(input string what);
        errors++;
        if (errors <= MAX_REPORTS) $display("ERROR: %s", what);
    endtask

    // one request: optional idle cycles, then hold valid until the engine takes it
    // (returns right after the accepting rising edge)
    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [CHAR_W-1:0] code,
                                input logic [ROW_W-1:0] rd_row,
                                input logic [COL_W-1:0] rd_col);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_kind      <= kind;
        i_char_code <= code;
        i_read_row  <= rd_row;
        i_read_col  <= rd_col;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        tracker.note_command(kind, code, rd_row, rd_col);
        sent++;
    endtask

    // the read fields carry noise on every command that ignores them
    task automatic put_byte(input logic [CHAR_W-1:0] code);
        send_request(KIND_PUT, code, ROW_W'($urandom), COL_W'($urandom));
    endtask

    task automatic read_cell(input int unsigned r, input int unsigned c);
        send_request(KIND_READ, CHAR_W'($urandom), ROW_W'(r), COL_W'(c));
    endtask

    task automatic plain_cmd(input logic [KIND_W-1:0] kind);
        send_request(kind, CHAR_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
    endtask

    task automatic random_phase();
        int  pick;
        int  burst;
        int  fill_pct;
        int  rsel;
        int unsigned r;
        bit  hold_fired;
        bit  pause_done;
        hold_fired = 1'b0;
        pause_done = 1'b0;
        while (sent < ITEM_TARGET) begin
            // long result-side hold-off while requests keep coming
            if (sent >= 100 && !hold_fired) begin
                hold_pending = 1'b1;
                hold_fired   = 1'b1;
            end
            // request side goes quiet until every result is back
            if (sent >= 250 && !pause_done) begin
                pause_done = 1'b1;
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                while (tracker.outstanding() != 0) @(posedge i_clk);
            end
            calm = (sent >= 150 && sent < 230);

            // full-row fills are what wrap on the bottom row, so favor them there
            fill_pct = (tracker.row == ROWS - 1) ? 12 : 4;
            pick     = $urandom_range(99);
            if (pick < fill_pct) begin
                burst = COLS - tracker.col + $urandom_range(3);
                repeat (burst) put_byte(CHAR_W'($urandom));
            end else if (pick < 40) begin
                repeat ($urandom_range(16, 1)) put_byte(CHAR_W'($urandom));
            end else if (pick < 56) begin
                // line breaks walk the cursor down, and each one on the bottom row scrolls
                repeat ($urandom_range(10, 1)) put_byte($urandom_range(1) ? CODE_NL : CODE_CR);
            end else if (pick < 66) begin
                repeat ($urandom_range(6, 1)) plain_cmd(KIND_DEL);
            end else if (pick < 84) begin
                repeat ($urandom_range(4, 1)) begin
                    rsel = $urandom_range(99);
                    if (rsel < 70) begin
                        // near the cursor, where text actually sits
                        r = tracker.row;
                        if (r > 0 && $urandom_range(1)) r--;
                        read_cell(r, $urandom_range(COLS - 1));
                    end else if (rsel < 85) begin
                        read_cell($urandom_range(ROWS - 1), $urandom_range(COLS - 1));
                    end else begin
                        // whole field range, out of range cells included
                        read_cell($urandom_range(31), $urandom_range(127));
                    end
                end
            end else if (pick < 87) begin
                plain_cmd(KIND_HOME);
            end else if (pick < 89) begin
                plain_cmd(KIND_CLEAR);
            end else if (pick < 94) begin
                plain_cmd(KIND_W'($urandom_range(KIND_SPARE_LAST, KIND_SPARE_FIRST)));
            end else begin
                send_request(KIND_W'($urandom), CHAR_W'($urandom), ROW_W'($urandom),
                             COL_W'($urandom));
            end
        end
        calm = 1'b0;
    endtask

    // result side: random stalls, plus the long hold-off when asked
    always @(negedge i_clk) begin
        if (hold_pending && hold_left == 0) begin
            hold_left    = HOLD_CYCLES;
            hold_pending = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // result checking at the rising edge
    always @(posedge i_clk) begin
        string msg;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            msg = tracker.check_result({o_cell_char, o_cur_col, o_cur_row, o_cur_linear});
            if (msg != "") report(msg);
        end
    end

    // watchdog: any handshake on either side restarts the count
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready === 1'b1) || (o_out_valid === 1'b1 && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG) begin
                $display("timeout: no handshake for %0d cycles", WATCHDOG);
                $display("** text_console_cursor_scroll_top: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // fresh store reads back zero, delete at the origin does nothing
        read_cell(0, 0);
        plain_cmd(KIND_DEL);
        // byte extremes on the top row
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(8'h41);
        read_cell(0, 1);
        read_cell(0, 2);
        // reads out of range and at the far corner
        read_cell(31, 127);
        read_cell(ROWS, 0);
        read_cell(0, COLS);
        read_cell(ROWS - 1, COLS - 1);
        // unused kinds only report the cursor
        for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++) plain_cmd(KIND_W'(k));
        // both line break codes, then delete across the line start
        put_byte(CODE_NL);
        put_byte(CODE_CR);
        plain_cmd(KIND_DEL);
        // print in the last column, which wraps to the next row
        put_byte(8'h7E);
        read_cell(1, COLS - 1);
        plain_cmd(KIND_HOME);
        plain_cmd(KIND_CLEAR);
        read_cell(1, COLS - 1);

        random_phase();

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("** text_console_cursor_scroll_top: PASSED **");
        end else begin
            $display("** text_console_cursor_scroll_top: FAILED **");
        end
        $finish;
    end

endmodule
